### rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants of the bus region decoder with bit-band aliasing.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam logic [1:0] MODE_MAP  = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_RESP = 2'd3;

  localparam logic [1:0] KIND_DEV = 2'd0;
  localparam logic [1:0] KIND_BUS = 2'd1;
  localparam logic [1:0] KIND_MAP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNMAPPED = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_DEVERR   = 3'd5;
  localparam logic [2:0] ST_BUSY     = 3'd6;

  localparam logic [2:0] WK_IDLE      = 3'd0;
  localparam logic [2:0] WK_READ      = 3'd1;
  localparam logic [2:0] WK_WRITE     = 3'd2;
  localparam logic [2:0] WK_BB_READ   = 3'd3;
  localparam logic [2:0] WK_BB_RMW_RD = 3'd4;
  localparam logic [2:0] WK_BB_RMW_WR = 3'd5;

  localparam logic [1:0] WIDTH_WORD = 2'd2;

  localparam logic [31:0] BAND0_LO = 32'h2200_0000;
  localparam logic [31:0] BAND0_HI = 32'h2400_0000;
  localparam logic [31:0] BASE0    = 32'h2000_0000;
  localparam logic [31:0] BAND1_LO = 32'h4200_0000;
  localparam logic [31:0] BAND1_HI = 32'h4400_0000;
  localparam logic [31:0] BASE1    = 32'h4000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] addr;
    logic [32:0] limit_addr;
    logic [31:0] wdata;
    logic [1:0]  width;
    logic [3:0]  device_id;
    logic        device_present;
    logic [31:0] resp_data;
    logic        resp_ok;
    logic [3:0]  resp_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] rdata;
    logic [3:0]  dev_id;
    logic [31:0] dev_offset;
    logic        dev_write;
    logic [31:0] dev_data;
    logic [1:0]  dev_width;
    logic [3:0]  dev_code;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic        is_bb;
    logic [31:0] addr;
    logic [32:0] limit_addr;
    logic [31:0] wdata;
    logic [1:0]  width;
    logic [3:0]  device_id;
    logic        device_present;
    logic [4:0]  bit_sel;
    logic [31:0] resp_data;
    logic        resp_ok;
    logic [3:0]  resp_code;
  } cls_word_t;

endpackage

### rtl/brd_if.sv
// ----------------------------------------------------------------------------
// brd_in_if / brd_out_if
// Valid/ready channels for input and result words.
// ----------------------------------------------------------------------------
interface brd_in_if;
  logic                valid;
  logic                ready;
  brd_pkg::in_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brd_out_if;
  logic                valid;
  logic                ready;
  brd_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/bus_region_decoder_bit_band_unit.sv
// ----------------------------------------------------------------------------
// bus_region_decoder_bit_band_unit
// Region table decoder with bit-band alias translation.
// ----------------------------------------------------------------------------
// An accepted input word is held in the front queue; its result word is registered in the back end when it is popped.
// Throughput: one word per cycle while the result side takes words.
// The table compare stage sets the rate; a two-entry queue decouples it.
// Reset clears region count, pending access and queues; table entries hold.
module bus_region_decoder_bit_band_unit #(
  parameter int REGIONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brd_pkg::out_word_t  out_data
);
  import brd_pkg::*;

  brd_in_if  in_ch ();
  brd_out_if out_ch ();
  logic      q_valid, q_pop;
  cls_word_t q_data;

  assign in_ch.valid = in_valid;
  assign in_ch.data = in_data;
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_data = out_ch.data;
  assign out_ch.ready = out_ready;

  brd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  brd_back #(.REGIONS(REGIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule

### rtl/brd_front.sv
// ----------------------------------------------------------------------------
// brd_front
// Accept input words, decode bit-band aliases, push into a two-entry queue.
// ----------------------------------------------------------------------------
module brd_front (
  input  logic                clk,
  input  logic                rst_n,
  brd_in_if.sink              in_ch,
  output logic                q_valid,
  output brd_pkg::cls_word_t  q_data,
  input  logic                q_pop
);
  import brd_pkg::*;

  cls_word_t  q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  logic       push;
  cls_word_t  cls;
  logic [31:0] a, off, tbyte;
  logic       in0, in1;

  always_comb begin
    a   = in_ch.data.addr;
    in0 = (a >= BAND0_LO) && (a < BAND0_HI);
    in1 = (a >= BAND1_LO) && (a < BAND1_HI);
    off = a - (in1 ? BAND1_LO : BAND0_LO);
    tbyte = (in1 ? BASE1 : BASE0) + (off >> 5);
    cls.mode = in_ch.data.mode;
    cls.is_bb = (in0 || in1) &&
                ((in_ch.data.mode == MODE_READ) || (in_ch.data.mode == MODE_WRITE));
    cls.addr = cls.is_bb ? {tbyte[31:2], 2'b00} : a;
    cls.limit_addr = in_ch.data.limit_addr;
    cls.wdata = in_ch.data.wdata;
    cls.width = (in_ch.data.width == 2'd3) ? WIDTH_WORD : in_ch.data.width;
    cls.device_id = in_ch.data.device_id;
    cls.device_present = in_ch.data.device_present;
    cls.bit_sel = {tbyte[1:0], off[4:2]};
    cls.resp_data = in_ch.data.resp_data;
    cls.resp_ok = in_ch.data.resp_ok;
    cls.resp_code = in_ch.data.resp_code;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_r] <= cls;
        wr_r <= ~wr_r;
      end
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2)
    else $error("full queue lost a word");
endmodule

### rtl/brd_back.sv
// ----------------------------------------------------------------------------
// brd_back
// Region table, map checks, decode lookup, pending access tracking.
// ----------------------------------------------------------------------------
module brd_back #(
  parameter int REGIONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  brd_pkg::cls_word_t  q_data,
  output logic                q_pop,
  brd_out_if.source           out_ch
);
  import brd_pkg::*;

  localparam int SW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CW = $clog2(REGIONS + 1);

  logic [31:0] start_r [REGIONS];
  logic [32:0] end_r   [REGIONS];
  logic [3:0]  dev_r   [REGIONS];
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]  wait_r, wait_nxt;
  logic [4:0]  bsel_r, bsel_nxt;
  logic        setv_r, setv_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [31:0] toff_r, toff_nxt;
  logic        ov_r;
  out_word_t   o_r, o_nxt;
  logic        emit, wr_map;

  logic [REGIONS-1:0] hit, ovl;
  logic          found;
  logic [SW-1:0] fslot;
  logic [31:0]   mask;

  always_comb begin
    hit = '0;
    ovl = '0;
    for (int i = 0; i < REGIONS; i++) begin
      if (CW'(i) < count_r) begin
        hit[i] = (q_data.addr >= start_r[i]) && ({1'b0, q_data.addr} < end_r[i]);
        ovl[i] = ({1'b0, q_data.addr} < end_r[i]) &&
                 ({1'b0, start_r[i]} < q_data.limit_addr);
      end
    end
    found = 1'b0;
    fslot = '0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        fslot = SW'(i);
      end
    end
  end

  assign q_pop = q_valid && (!ov_r || out_ch.ready);

  always_comb begin
    count_nxt = count_r;
    wait_nxt = wait_r;
    bsel_nxt = bsel_r;
    setv_nxt = setv_r;
    slot_nxt = slot_r;
    toff_nxt = toff_r;
    o_nxt = '0;
    emit = 1'b1;
    wr_map = 1'b0;
    mask = 32'd1 << bsel_r;
    case (q_data.mode)
      MODE_MAP: begin
        o_nxt.kind = KIND_MAP;
        if (!q_data.device_present) o_nxt.status = ST_INVALID;
        else if (|ovl) o_nxt.status = ST_OVERLAP;
        else if (count_r >= CW'(REGIONS)) o_nxt.status = ST_FULL;
        else begin
          o_nxt.status = ST_OK;
          wr_map = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_READ, MODE_WRITE: begin
        o_nxt.kind = KIND_BUS;
        if (wait_r != WK_IDLE) o_nxt.status = ST_BUSY;
        else if (!found) o_nxt.status = ST_UNMAPPED;
        else begin
          o_nxt.kind = KIND_DEV;
          o_nxt.dev_id = dev_r[fslot];
          o_nxt.dev_offset = q_data.addr - start_r[fslot];
          if (q_data.is_bb) begin
            o_nxt.dev_width = WIDTH_WORD;
            bsel_nxt = q_data.bit_sel;
            slot_nxt = fslot;
            toff_nxt = q_data.addr - start_r[fslot];
            setv_nxt = (q_data.mode == MODE_WRITE) && (q_data.wdata != 32'd0);
            wait_nxt = (q_data.mode == MODE_WRITE) ? WK_BB_RMW_RD : WK_BB_READ;
          end else begin
            o_nxt.dev_width = q_data.width;
            o_nxt.dev_write = (q_data.mode == MODE_WRITE);
            o_nxt.dev_data = (q_data.mode == MODE_WRITE) ? q_data.wdata : 32'd0;
            wait_nxt = (q_data.mode == MODE_WRITE) ? WK_WRITE : WK_READ;
          end
        end
      end
      default: begin
        o_nxt.kind = KIND_BUS;
        if (wait_r == WK_IDLE) emit = 1'b0;
        else if (!q_data.resp_ok) begin
          o_nxt.status = ST_DEVERR;
          o_nxt.dev_code = q_data.resp_code;
          wait_nxt = WK_IDLE;
        end else begin
          wait_nxt = WK_IDLE;
          case (wait_r)
            WK_READ: o_nxt.rdata = q_data.resp_data;
            WK_BB_READ: o_nxt.rdata = {31'd0, q_data.resp_data[bsel_r]};
            WK_BB_RMW_RD: begin
              o_nxt.kind = KIND_DEV;
              o_nxt.dev_id = dev_r[slot_r];
              o_nxt.dev_offset = toff_r;
              o_nxt.dev_write = 1'b1;
              o_nxt.dev_data = setv_r ? (q_data.resp_data | mask)
                                      : (q_data.resp_data & ~mask);
              o_nxt.dev_width = WIDTH_WORD;
              wait_nxt = WK_BB_RMW_WR;
            end
            default: o_nxt.rdata = 32'd0;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wait_r <= WK_IDLE;
      bsel_r <= '0;
      setv_r <= 1'b0;
      slot_r <= '0;
      toff_r <= '0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= (q_pop && emit) || (ov_r && !out_ch.ready);
      if (q_pop) begin
        count_r <= count_nxt;
        wait_r <= wait_nxt;
        bsel_r <= bsel_nxt;
        setv_r <= setv_nxt;
        slot_r <= slot_nxt;
        toff_r <= toff_nxt;
        if (emit) o_r <= o_nxt;
        if (wr_map) begin
          start_r[count_r[SW-1:0]] <= q_data.addr;
          end_r[count_r[SW-1:0]] <= q_data.limit_addr;
          dev_r[count_r[SW-1:0]] <= q_data.device_id;
        end
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(REGIONS))
    else $error("region count above table size");
  assert property (@(posedge clk) disable iff (!rst_n) wait_r <= WK_BB_RMW_WR)
    else $error("bad wait code");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.mode == MODE_MAP) |=> ov_r)
    else $error("map word gave no result");
endmodule
